### rtl/npcm_pkg.sv
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared types, codes and constants of the nearest palette color match unit.
// ----------------------------------------------------------------------------
`default_nettype none

package npcm_pkg;

	// Default palette depth and fixed field widths.
	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int CHAN_W            = 8;
	localparam int INDEX_W           = 8;
	localparam int DIST_W            = 10;
	localparam int SUM_W             = 10;
	localparam int ENTRY_W           = 3 * CHAN_W;

	// Command codes carried in tuser.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_MATCH = 1'b1;

	// Configuration register indexes.
	localparam int  CFG_IDX_W          = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAY_PALETTE   = 1'd1;
	localparam int  CFG_DATA_W         = 8;

	// Division by three as multiply by 683 and shift right by 11.
	// Exact for every channel sum up to 765.
	localparam logic [SUM_W-1:0] DIV3_MUL   = 10'd683;
	localparam int               DIV3_SHIFT = 11;

	// Start request from the top level to the search sequencer.
	typedef struct packed {
		logic              start;
		logic              gray;
		logic [CHAN_W-1:0] pix0;
		logic [CHAN_W-1:0] pix1;
		logic [CHAN_W-1:0] pix2;
	} match_req_t;

	// Finished result from the search sequencer.
	typedef struct packed {
		logic               valid;
		logic [INDEX_W-1:0] index;
	} match_res_t;

	// Absolute difference of two channel bytes.
	function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b);
		logic [CHAN_W-1:0] r;
		if (a > b) begin
			r = a - b;
		end else begin
			r = b - a;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/npcm_palette_mem.sv
// ----------------------------------------------------------------------------
// npcm_palette_mem
// Palette storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module npcm_palette_mem #(
	parameter int DEPTH  = npcm_pkg::PALETTE_DEPTH_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic [ADDR_W-1:0]           wr_addr,
	input  wire logic [npcm_pkg::ENTRY_W-1:0] wr_data,
	input  wire logic                        rd_en,
	input  wire logic [ADDR_W-1:0]           rd_addr,
	output logic      [npcm_pkg::ENTRY_W-1:0] rd_data
);

	logic [npcm_pkg::ENTRY_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### rtl/npcm_search.sv
// ----------------------------------------------------------------------------
// npcm_search
// Search sequencer: walks the palette one entry per cycle, computes the
// distance of each entry to the pixel and keeps the first closest index.
// ----------------------------------------------------------------------------
`default_nettype none

module npcm_search #(
	parameter int DEPTH  = npcm_pkg::PALETTE_DEPTH_DEF,
	parameter int ADDR_W = $clog2(DEPTH),
	parameter int CNT_W  = $clog2(DEPTH + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire npcm_pkg::match_req_t          req,
	input  wire logic [CNT_W-1:0]              count,
	output logic                               idle,
	output npcm_pkg::match_res_t               res,
	input  wire logic                          res_ready,
	output logic                               rd_en,
	output logic [ADDR_W-1:0]                  rd_addr,
	input  wire logic [npcm_pkg::ENTRY_W-1:0]  rd_data
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]                     state_q;
	logic [CNT_W-1:0]               k_q;
	logic [CNT_W-1:0]               count_q;
	logic                           gray_q;
	logic [npcm_pkg::CHAN_W-1:0]    pix0_q;
	logic [npcm_pkg::CHAN_W-1:0]    pix1_q;
	logic [npcm_pkg::CHAN_W-1:0]    pix2_q;
	logic [npcm_pkg::CHAN_W-1:0]    bright_q;
	logic [npcm_pkg::DIST_W-1:0]    best_dist_q;
	logic [ADDR_W-1:0]              best_idx_q;

	logic                           v_s1;
	logic                           last_s1;
	logic [ADDR_W-1:0]              idx_s1;
	logic                           v_s2;
	logic                           last_s2;
	logic [ADDR_W-1:0]              idx_s2;
	logic [npcm_pkg::DIST_W-1:0]    dist_s2;

	logic [npcm_pkg::SUM_W-1:0]     pix_sum;
	logic [2*npcm_pkg::SUM_W-1:0]   bright_prod;
	logic [npcm_pkg::CHAN_W-1:0]    bright;
	logic                           k_last;
	logic [npcm_pkg::DIST_W-1:0]    ent_dist;
	logic [npcm_pkg::CHAN_W-1:0]    e0;
	logic [npcm_pkg::CHAN_W-1:0]    e1;
	logic [npcm_pkg::CHAN_W-1:0]    e2;

	// Pixel brightness: channel sum divided by three through a reciprocal.
	assign pix_sum = npcm_pkg::SUM_W'(req.pix0) + npcm_pkg::SUM_W'(req.pix1)
			+ npcm_pkg::SUM_W'(req.pix2);
	assign bright_prod = pix_sum * npcm_pkg::DIV3_MUL;
	assign bright = npcm_pkg::CHAN_W'(bright_prod >> npcm_pkg::DIV3_SHIFT);

	// Address issue.
	assign k_last  = (k_q == count_q - CNT_W'(1));
	assign rd_en   = (state_q == ST_RUN);
	assign rd_addr = k_q[ADDR_W-1:0];

	assign idle      = (state_q == ST_IDLE);
	assign res.valid = (state_q == ST_FIN);
	assign res.index = npcm_pkg::INDEX_W'(best_idx_q);

	// Distance of the entry read from memory.
	assign e0 = rd_data[npcm_pkg::CHAN_W-1:0];
	assign e1 = rd_data[2*npcm_pkg::CHAN_W-1:npcm_pkg::CHAN_W];
	assign e2 = rd_data[3*npcm_pkg::CHAN_W-1:2*npcm_pkg::CHAN_W];

	always_comb begin
		if (gray_q) begin
			ent_dist = npcm_pkg::DIST_W'(npcm_pkg::abs_diff(e0, bright_q));
		end else begin
			ent_dist = npcm_pkg::DIST_W'(npcm_pkg::abs_diff(e0, pix0_q))
					+ npcm_pkg::DIST_W'(npcm_pkg::abs_diff(e1, pix1_q))
					+ npcm_pkg::DIST_W'(npcm_pkg::abs_diff(e2, pix2_q));
		end
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						k_q <= '0;
						if (count == '0) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					k_q <= k_q + CNT_W'(1);
					if (k_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (v_s2 && last_s2) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Pipeline valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		last_s1 <= k_last;
		idx_s1  <= k_q[ADDR_W-1:0];
		last_s2 <= last_s1;
		idx_s2  <= idx_s1;
		dist_s2 <= ent_dist;
	end

	// Request capture and running minimum.
	always_ff @(posedge clk) begin
		if (idle && req.start) begin
			count_q     <= count;
			gray_q      <= req.gray;
			pix0_q      <= req.pix0;
			pix1_q      <= req.pix1;
			pix2_q      <= req.pix2;
			bright_q    <= bright;
			best_dist_q <= '1;
			best_idx_q  <= '0;
		end else if (v_s2 && (dist_s2 < best_dist_q)) begin
			best_dist_q <= dist_s2;
			best_idx_q  <= idx_s2;
		end
	end

`ifndef SYNTHESIS
	// The pipeline is empty once a result is offered.
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> (!v_s1 && !v_s2))
		else $error("result offered with reads still in flight");

	// A pending result stays offered until it is taken.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res_ready) |=> (res.valid && $stable(res.index)))
		else $error("pending result dropped or changed");

	// The winning index lies inside the searched range.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FIN) && (count_q != '0)) |->
			(CNT_W'(best_idx_q) < count_q))
		else $error("closest index outside searched entries");

	// Memory reads stop once the last address has been issued.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && k_last) |=> !rd_en)
		else $error("read issued past the last entry");
`endif

endmodule

`default_nettype wire

### rtl/nearest_palette_color_match_unit.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_match_unit
// Palette store with nearest color search by L1 distance.
// ----------------------------------------------------------------------------
// A write word (tuser command 0) stores one palette entry and produces no
// output word; a slot at or above PALETTE_DEPTH is dropped.
// A match word (tuser command 1) searches entries 0 to entries_in_use - 1,
// capped at PALETTE_DEPTH, one entry per cycle through the single read port
// of the palette memory, and returns the index of the first closest entry.
// Palette read data and each entry's distance are registered before the
// running minimum is updated, and the result is handed off into the output
// register; an empty search skips the reads. Input is accepted only while
// the search sequencer is idle, also while a result waits in the output register.
// Entries must be written before a match reads them. Configuration may be
// written only while no match is in progress.
`default_nettype none

module nearest_palette_color_match_unit #(
	parameter int PALETTE_DEPTH = npcm_pkg::PALETTE_DEPTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Input stream.
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// entry_index, entry_chan0, entry_chan1, entry_chan2,
	// pixel_chan0, pixel_chan1, pixel_chan2 (8 bits each, lowest first)
	input  wire logic [55:0]                         s_axis_tdata,
	// command
	input  wire logic [0:0]                          s_axis_tuser,
	// Output stream.
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// closest_index
	output logic [7:0]                               m_axis_tdata,
	// Configuration write port.
	input  wire logic                                cfg_we,
	input  wire logic [npcm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [npcm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int ADDR_W = $clog2(PALETTE_DEPTH);
	localparam int CNT_W  = $clog2(PALETTE_DEPTH + 1);

	logic [7:0]                     entries_in_use_q;
	logic                           gray_palette_q;
	logic                           m_valid_q;
	logic [7:0]                     m_data_q;

	logic                           idle;
	logic                           accept;
	logic                           slot_ok;
	logic                           mem_wr_en;
	logic [npcm_pkg::ENTRY_W-1:0]   mem_wr_data;
	logic                           mem_rd_en;
	logic [ADDR_W-1:0]              mem_rd_addr;
	logic [npcm_pkg::ENTRY_W-1:0]   mem_rd_data;
	logic [8:0]                     count_full;
	logic [CNT_W-1:0]               count;
	logic                           res_ready;
	npcm_pkg::match_req_t           req;
	npcm_pkg::match_res_t           res;

	// Input handshake.
	assign s_axis_tready = idle;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Palette writes that land inside the memory.
	assign slot_ok     = ({1'b0, s_axis_tdata[7:0]} < 9'(PALETTE_DEPTH));
	assign mem_wr_en   = accept && (s_axis_tuser[0] == npcm_pkg::CMD_WRITE) && slot_ok;
	assign mem_wr_data = s_axis_tdata[31:8];

	// Match request and the searched count capped at the depth.
	assign req.start = accept && (s_axis_tuser[0] == npcm_pkg::CMD_MATCH);
	assign req.gray  = gray_palette_q;
	assign req.pix0  = s_axis_tdata[39:32];
	assign req.pix1  = s_axis_tdata[47:40];
	assign req.pix2  = s_axis_tdata[55:48];

	assign count_full = ({1'b0, entries_in_use_q} > 9'(PALETTE_DEPTH)) ?
			9'(PALETTE_DEPTH) : {1'b0, entries_in_use_q};
	assign count = CNT_W'(count_full);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_in_use_q <= 8'd2;
			gray_palette_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				npcm_pkg::CFG_ENTRIES_IN_USE: entries_in_use_q <= cfg_data;
				npcm_pkg::CFG_GRAY_PALETTE:   gray_palette_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Output register, refilled as the current word leaves.
	assign res_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res.valid && res_ready) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			m_data_q <= res.index;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	npcm_palette_mem #(
		.DEPTH  (PALETTE_DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (s_axis_tdata[ADDR_W-1:0]),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	npcm_search #(
		.DEPTH  (PALETTE_DEPTH),
		.ADDR_W (ADDR_W),
		.CNT_W  (CNT_W)
	) u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.count     (count),
		.idle      (idle),
		.res       (res),
		.res_ready (res_ready),
		.rd_en     (mem_rd_en),
		.rd_addr   (mem_rd_addr),
		.rd_data   (mem_rd_data)
	);

endmodule

`default_nettype wire

### tb/nearest_palette_color_match_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_palette_color_match_unit_test
// Self-checking bench for the palette store and nearest color search.
// ----------------------------------------------------------------------------
// A short table of write, match and register rows covers the edge values,
// ties, an empty search and grayscale mode. Then every slot is filled, and
// random phases follow, each with its own search count and gray mode. Each
// accepted match word gets an expected index, typed in the table or from a
// shadow search of a shadow palette. Each output word is compared with the
// oldest expected index. Both stream sides stall in random bursts, except near the end of the run.

module nearest_palette_color_match_unit_test;

	localparam int MIXED_ITEMS = 260;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 300;
	localparam int STALL_LIMIT = 3000;
	localparam int PLAN_LEN = 23;

	// One input word. Entry and pixel hold channel 2, 1, 0 from the top down.
	typedef struct packed {
		logic                         cmd;
		logic [npcm_pkg::INDEX_W-1:0] slot;
		logic [23:0]                  ent;
		logic [23:0]                  pix;
	} palette_word_t;

	typedef enum logic [1:0] {
		ROW_WORD,
		ROW_CFG
	} row_kind_t;

	// One row of the directed table. For a register row, slot holds the
	// register index and c0 the value written.
	typedef struct packed {
		row_kind_t                    kind;
		logic                         cmd;
		logic [npcm_pkg::INDEX_W-1:0] slot;
		logic [npcm_pkg::CHAN_W-1:0]  c0;
		logic [npcm_pkg::CHAN_W-1:0]  c1;
		logic [npcm_pkg::CHAN_W-1:0]  c2;
		logic                         typed;
		logic [npcm_pkg::INDEX_W-1:0] want;
	} plan_row_t;

	logic                            clk;
	logic                            arst_n;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	// entry_index, entry_chan0..2, pixel_chan0..2 (8 bits each, lowest first)
	logic [55:0]                     s_axis_tdata;
	// command
	logic [0:0]                      s_axis_tuser;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	// closest_index
	logic [7:0]                      m_axis_tdata;
	logic                            cfg_we;
	logic [npcm_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [npcm_pkg::CFG_DATA_W-1:0] cfg_data;

	// Shadow of the block state and the queue of expected indexes.
	logic [23:0]                  palette_shadow [256];
	logic [7:0]                   entries_shadow;
	logic                         gray_shadow;
	logic [npcm_pkg::INDEX_W-1:0] closest_expected [$];

	plan_row_t plan [PLAN_LEN];
	bit        calm_tail;
	int        errors;
	int        writes_sent;
	int        matches_sent;
	int        results_checked;
	int        settings_applied;

	nearest_palette_color_match_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned byte_gap(input int unsigned a, input int unsigned b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	// Nearest shadow entry by L1 distance, or channel 0 against brightness in
	// gray mode. Strict less-than keeps the first of equal entries.
	function automatic logic [npcm_pkg::INDEX_W-1:0] nearest_entry(input logic [23:0] pix);
		int unsigned bright;
		int unsigned gap_sum;
		int unsigned best_dist;
		int unsigned k;
		logic [npcm_pkg::INDEX_W-1:0] best_idx;
		bright = (int'(pix[7:0]) + int'(pix[15:8]) + int'(pix[23:16])) / 3;
		best_dist = 32'hFFFF_FFFF;
		best_idx = '0;
		for (k = 0; k < entries_shadow; k++) begin
			if (gray_shadow) begin
				gap_sum = byte_gap(32'(palette_shadow[k][7:0]), bright);
			end else begin
				gap_sum = byte_gap(32'(palette_shadow[k][7:0]), 32'(pix[7:0]))
					+ byte_gap(32'(palette_shadow[k][15:8]), 32'(pix[15:8]))
					+ byte_gap(32'(palette_shadow[k][23:16]), 32'(pix[23:16]));
			end
			if (gap_sum < best_dist) begin
				best_dist = gap_sum;
				best_idx = k[7:0];
			end
		end
		return best_idx;
	endfunction

	// Random word for the mixed phases. Slots and pixels lean toward the
	// searched range and toward copies of stored entries, so ties show up.
	function automatic palette_word_t random_word();
		palette_word_t w;
		int unsigned top;
		int unsigned sel;
		int c;
		top = (entries_shadow == 0) ? 0 : entries_shadow - 1;
		w.cmd = ($urandom_range(0, 9) < 6) ? npcm_pkg::CMD_MATCH : npcm_pkg::CMD_WRITE;
		w.slot = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, top));
		w.ent = ($urandom_range(0, 4) == 0) ? palette_shadow[$urandom_range(0, 255)]
			: 24'($urandom);
		sel = $urandom_range(0, 7);
		if (sel < 2) begin
			w.pix = palette_shadow[$urandom_range(0, top)];
		end else if (sel == 2) begin
			for (c = 0; c < 3; c++) begin
				case ($urandom_range(0, 2))
					0: w.pix[c*8 +: 8] = 8'h00;
					1: w.pix[c*8 +: 8] = 8'hFF;
					default: w.pix[c*8 +: 8] = 8'($urandom);
				endcase
			end
		end else begin
			w.pix = 24'($urandom);
		end
		return w;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("%0t mismatch: %s, got %0d, want %0d", $time, what, got, want);
	endtask

	// Offer one word and hold it until accepted, with an optional gap first.
	// A typed expectation replaces the predicted one for a directed match.
	task automatic send_word(input palette_word_t w, input bit typed,
			input logic [npcm_pkg::INDEX_W-1:0] want);
		if (!calm_tail && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= w.cmd;
		s_axis_tdata <= {w.pix, w.ent, w.slot};
		do @(posedge clk); while (!s_axis_tready);
		if (w.cmd == npcm_pkg::CMD_WRITE) begin
			palette_shadow[w.slot] = w.ent;
			writes_sent++;
		end else begin
			closest_expected.push_back(typed ? want : nearest_entry(w.pix));
			matches_sent++;
		end
	endtask

	// Register write once the block is idle: no result pending and a settle
	// wait for a trailing palette write to finish.
	task automatic set_register(input logic [npcm_pkg::CFG_IDX_W-1:0] idx,
			input logic [npcm_pkg::CFG_DATA_W-1:0] val);
		s_axis_tvalid <= 1'b0;
		while (closest_expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == npcm_pkg::CFG_ENTRIES_IN_USE) begin
			entries_shadow = val;
		end else begin
			gray_shadow = val[0];
		end
		settings_applied++;
	endtask

	task automatic close_run(input bit timed_out);
		if (closest_expected.size() != 0) begin
			report_mismatch("results never arrived", 0, closest_expected.size());
		end
		$display("covered %0d palette writes, %0d matches, %0d register writes",
			writes_sent, matches_sent, settings_applied);
		$display("checked %0d closest indexes, %0d mismatches", results_checked, errors);
		if (errors == 0 && !timed_out) begin
			$display("nearest_palette_color_match_unit_test: done, clean");
		end else begin
			$display("nearest_palette_color_match_unit_test: done, errors");
		end
		$finish;
	endtask

	// Output side: check each accepted word, then stall in random bursts.
	initial begin : result_sink
		int stall_left;
		logic [npcm_pkg::INDEX_W-1:0] want;
		stall_left = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (closest_expected.size() == 0) begin
					report_mismatch("result with nothing expected", int'(m_axis_tdata), 0);
				end else begin
					want = closest_expected.pop_front();
					if (m_axis_tdata[7:0] !== want) begin
						report_mismatch("closest_index", int'(m_axis_tdata[7:0]),
							int'(want));
					end
					results_checked++;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 17) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog: ends the run when no word moves for too long.
	initial begin : watchdog
		int stuck_cycles;
		stuck_cycles = 0;
		@(posedge arst_n);
		while (stuck_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| cfg_we) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
			end
		end
		$display("%0t watchdog: no word moved for %0d cycles", $time, STALL_LIMIT);
		close_run(1'b1);
	end

	// Stimulus: directed table, palette fill, then random phases.
	initial begin : stimulus
		palette_word_t w;
		plan_row_t row;
		int i;
		int s;
		int phase;
		int burst;
		int mixed_sent;
		logic [7:0] count_val;
		logic [7:0] gray_val;

		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= npcm_pkg::CMD_WRITE;
		cfg_we <= 1'b0;
		cfg_index <= npcm_pkg::CFG_ENTRIES_IN_USE;
		cfg_data <= '0;
		calm_tail = 1'b0;
		errors = 0;
		writes_sent = 0;
		matches_sent = 0;
		results_checked = 0;
		settings_applied = 0;
		entries_shadow = 8'd2;
		gray_shadow = 1'b0;

		// Black and white entries, searched with the reset count of two.
		plan[0]  = '{ROW_WORD, npcm_pkg::CMD_WRITE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0};
		plan[1]  = '{ROW_WORD, npcm_pkg::CMD_WRITE, 8'd1, 8'd255, 8'd255, 8'd255,
			1'b0, 8'd0};
		plan[2]  = '{ROW_WORD, npcm_pkg::CMD_MATCH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0};
		plan[3]  = '{ROW_WORD, npcm_pkg::CMD_MATCH, 8'd0, 8'd255, 8'd255, 8'd255,
			1'b1, 8'd1};
		plan[4]  = '{ROW_WORD, npcm_pkg::CMD_MATCH, 8'd0, 8'd128, 8'd127, 8'd127,
			1'b0, 8'd0};
		plan[5]  = '{ROW_WORD, npcm_pkg::CMD_MATCH, 8'd0, 8'd127, 8'd128, 8'd128,
			1'b0, 8'd0};
		// Highest slot, and a duplicate of entry 0 so ties must pick the first.
		plan[6]  = '{ROW_WORD, npcm_pkg::CMD_WRITE, 8'd255, 8'd255, 8'd0, 8'd255,
			1'b0, 8'd0};
		plan[7]  = '{ROW_WORD, npcm_pkg::CMD_WRITE, 8'd2, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0};
		plan[8]  = '{ROW_CFG, npcm_pkg::CMD_WRITE, 8'(npcm_pkg::CFG_ENTRIES_IN_USE),
			8'd3, 8'd0, 8'd0, 1'b0, 8'd0};
		plan[9]  = '{ROW_WORD, npcm_pkg::CMD_MATCH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0};
		plan[10] = '{ROW_WORD, npcm_pkg::CMD_MATCH, 8'd0, 8'd1, 8'd0, 8'd0, 1'b0, 8'd0};
		// An empty search returns index zero.
		plan[11] = '{ROW_CFG, npcm_pkg::CMD_WRITE, 8'(npcm_pkg::CFG_ENTRIES_IN_USE),
			8'd0, 8'd0, 8'd0, 1'b0, 8'd0};
		plan[12] = '{ROW_WORD, npcm_pkg::CMD_MATCH, 8'd0, 8'd255, 8'd255, 8'd255,
			1'b1, 8'd0};
		plan[13] = '{ROW_CFG, npcm_pkg::CMD_WRITE, 8'(npcm_pkg::CFG_GRAY_PALETTE),
			8'd1, 8'd0, 8'd0, 1'b0, 8'd0};
		plan[14] = '{ROW_WORD, npcm_pkg::CMD_MATCH, 8'd0, 8'd90, 8'd200, 8'd10,
			1'b1, 8'd0};
		// Grayscale search over four entries.
		plan[15] = '{ROW_WORD, npcm_pkg::CMD_WRITE, 8'd3, 8'd128, 8'd0, 8'd0,
			1'b0, 8'd0};
		plan[16] = '{ROW_CFG, npcm_pkg::CMD_WRITE, 8'(npcm_pkg::CFG_ENTRIES_IN_USE),
			8'd4, 8'd0, 8'd0, 1'b0, 8'd0};
		plan[17] = '{ROW_WORD, npcm_pkg::CMD_MATCH, 8'd0, 8'd255, 8'd255, 8'd254,
			1'b0, 8'd0};
		plan[18] = '{ROW_WORD, npcm_pkg::CMD_MATCH, 8'd0, 8'd64, 8'd64, 8'd65,
			1'b0, 8'd0};
		plan[19] = '{ROW_WORD, npcm_pkg::CMD_MATCH, 8'd0, 8'd0, 8'd255, 8'd255,
			1'b0, 8'd0};
		// Back to color with a single entry searched.
		plan[20] = '{ROW_CFG, npcm_pkg::CMD_WRITE, 8'(npcm_pkg::CFG_GRAY_PALETTE),
			8'd0, 8'd0, 8'd0, 1'b0, 8'd0};
		plan[21] = '{ROW_CFG, npcm_pkg::CMD_WRITE, 8'(npcm_pkg::CFG_ENTRIES_IN_USE),
			8'd1, 8'd0, 8'd0, 1'b0, 8'd0};
		plan[22] = '{ROW_WORD, npcm_pkg::CMD_MATCH, 8'd0, 8'd255, 8'd0, 8'd255,
			1'b1, 8'd0};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; fields a row does not use get random values.
		for (i = 0; i < PLAN_LEN; i++) begin
			row = plan[i];
			if (row.kind == ROW_CFG) begin
				set_register(row.slot[npcm_pkg::CFG_IDX_W-1:0], row.c0);
			end else begin
				w.cmd = row.cmd;
				w.slot = (row.cmd == npcm_pkg::CMD_WRITE) ? row.slot : 8'($urandom);
				w.ent = (row.cmd == npcm_pkg::CMD_WRITE) ? {row.c2, row.c1, row.c0}
					: 24'($urandom);
				w.pix = (row.cmd == npcm_pkg::CMD_MATCH) ? {row.c2, row.c1, row.c0}
					: 24'($urandom);
				send_word(w, row.typed, row.want);
			end
		end

		// Fill every slot so any later search reads written entries only.
		for (s = 0; s < 256; s++) begin
			w.cmd = npcm_pkg::CMD_WRITE;
			w.slot = s[7:0];
			w.ent = (s > 0 && $urandom_range(0, 5) == 0)
				? palette_shadow[$urandom_range(0, s - 1)] : 24'($urandom);
			w.pix = 24'($urandom);
			send_word(w, 1'b0, '0);
		end

		// Random phases. The first ones pin the extremes of both registers.
		mixed_sent = 0;
		phase = 0;
		while (mixed_sent < MIXED_ITEMS) begin
			case (phase)
				0: begin
					count_val = 8'd255;
					gray_val = 8'h00;
				end
				1: begin
					count_val = 8'd255;
					gray_val = 8'hFF;
				end
				2: begin
					count_val = 8'd0;
					gray_val = 8'h00;
				end
				default: begin
					case ($urandom_range(0, 19))
						0: count_val = 8'd0;
						1: count_val = 8'd255;
						2: count_val = 8'd1;
						default: count_val = 8'($urandom_range(2, 24));
					endcase
					gray_val = {7'($urandom), 1'($urandom_range(0, 1))};
				end
			endcase
			set_register(npcm_pkg::CFG_ENTRIES_IN_USE, count_val);
			set_register(npcm_pkg::CFG_GRAY_PALETTE, gray_val);
			burst = $urandom_range(8, 40);
			for (i = 0; i < burst && mixed_sent < MIXED_ITEMS; i++) begin
				calm_tail = (MIXED_ITEMS - mixed_sent) <= 40;
				send_word(random_word(), 1'b0, '0);
				mixed_sent++;
			end
			phase++;
		end

		// Drain the remaining results, then watch for stray output words.
		s_axis_tvalid <= 1'b0;
		while (closest_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		close_run(1'b0);
	end

endmodule

### filelist.f
rtl/npcm_pkg.sv
rtl/npcm_palette_mem.sv
rtl/npcm_search.sv
rtl/nearest_palette_color_match_unit.sv
tb/nearest_palette_color_match_unit_test.sv
